// File: sv/rstab_pkg.sv
package rstab_pkg;

  // table geometry
  localparam int unsigned TableEntries = 64;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableEntries - 1);

  // fixed field widths
  localparam int unsigned CmdW = 2;
  localparam int unsigned KeyW = 31;
  localparam int unsigned ValW = 8;
  localparam int unsigned StatW = 2;
  localparam int unsigned SlotW = 6;

  typedef enum logic [CmdW-1:0] {
    CmdInsert = 2'd0,
    CmdLookup = 2'd1,
    CmdDelete = 2'd2
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    StDone     = 2'd0,
    StNotFound = 2'd1,
    StFull     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    FsmIdle,
    FsmScan,
    FsmPush
  } fsm_e;

  // one stored record
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } entry_t;

  // one result
  typedef struct packed {
    status_e          status;
    logic [SlotW-1:0] slot;
    logic [ValW-1:0]  value;
  } rsp_t;

  // low bits of a slot number, zero extended where the table is small
  function automatic logic [SlotW-1:0] to_slot(logic [IdxW-1:0] idx);
    logic [IdxW+SlotW-1:0] wide;
    wide = (IdxW + SlotW)'(idx);
    return wide[SlotW-1:0];
  endfunction

endpackage

// File: sv/rstab_if.sv
interface rstab_req_if;
  import rstab_pkg::*;
  logic            valid;
  logic            ready;
  logic [CmdW-1:0] command;
  logic [KeyW-1:0] record_key;
  logic [ValW-1:0] record_value;

  modport source (output valid, command, record_key, record_value, input ready);
  modport sink (input valid, command, record_key, record_value, output ready);
endinterface

interface rstab_rsp_if;
  import rstab_pkg::*;
  logic             valid;
  logic             ready;
  logic [StatW-1:0] status;
  logic [SlotW-1:0] slot_index;
  logic [ValW-1:0]  found_value;

  modport source (output valid, status, slot_index, found_value, input ready);
  modport sink (input valid, status, slot_index, found_value, output ready);
endinterface

// File: sv/rstab_ram.sv
module rstab_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/record_slot_table_unit.sv
// record slot table: a fixed table of key/value records with occupied marks
//
// req_i (sink) carries one command per transaction: insert, lookup or delete,
// with a 31-bit key and an 8-bit value (value used by insert only).
// rsp_o (source) returns exactly one transaction per command: status, slot
// index and found value.
//
// insert, lookup and delete scan the slots in ascending order, one slot per cycle.
// keys and values live in a single-port-write, registered-read ram; the
// occupied marks are flip-flops. an insert stops at the first free slot,
// lookup/delete at the first occupied slot with a matching key, compared on
// the registered ram read. an insert into a full table answers "full" and a
// lookup or delete that misses answers "not found". one command is in work at
// a time: the next is not taken until the last has finished its scan and push.
// an unknown command code answers "not found" without a scan.
//
// reset marks every slot free at once; no clearing pass is needed.
// a result waits in the output register while rsp_o.ready is low; the next
// command is still taken and scanned, then held until the register drains.
module record_slot_table_unit (
  input  logic clk_i,
  input  logic rst_ni,
  rstab_req_if.sink   req_i,
  rstab_rsp_if.source rsp_o
);
  import rstab_pkg::*;

  fsm_e state_q, state_d;
  cmd_e cmd_q;
  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] val_q;

  // scan pointer and the read in flight
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic            issued_all_q, issued_all_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d;

  logic [TableEntries-1:0] occ_q, occ_d;

  rsp_t res_q, res_d;
  rsp_t out_q, out_d;
  logic out_vld_q, out_vld_d;

  logic   ram_we;
  logic   ram_re;
  entry_t ram_wdata;
  entry_t ram_rdata;
  logic   hit;
  logic   accept;

  assign ram_wdata = '{key: key_q, value: val_q};
  assign accept    = req_i.valid && req_i.ready;

  rstab_ram #(
    .Width($bits(entry_t)),
    .Depth(TableEntries)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cnt_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(cnt_q),
    .rdata_o(ram_rdata)
  );

  // match on the entry read last cycle; free slots never match
  assign hit = cmp_vld_q && occ_q[cmp_idx_q] && (ram_rdata.key == key_q);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    issued_all_d = issued_all_q;
    cmp_vld_d    = cmp_vld_q;
    cmp_idx_d    = cmp_idx_q;
    occ_d        = occ_q;
    res_d        = res_q;
    out_d        = out_q;
    out_vld_d    = out_vld_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    req_i.ready  = (state_q == FsmIdle);

    // output register drains on a completed rsp transaction
    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      FsmIdle: begin
        if (req_i.valid) begin
          cnt_d        = '0;
          issued_all_d = 1'b0;
          cmp_vld_d    = 1'b0;
          unique case (cmd_e'(req_i.command)) inside
            CmdInsert, CmdLookup, CmdDelete: begin
              state_d = FsmScan;
            end
            default: begin
              res_d   = '{status: StNotFound, slot: '0, value: '0};
              state_d = FsmPush;
            end
          endcase
        end
      end

      FsmScan: begin
        case (cmd_q)
          CmdInsert: begin
            // first free slot takes the record
            if (!occ_q[cnt_q]) begin
              ram_we       = 1'b1;
              occ_d[cnt_q] = 1'b1;
              res_d        = '{status: StDone, slot: to_slot(cnt_q), value: '0};
              state_d      = FsmPush;
            end else if (cnt_q == LastIdx) begin
              res_d   = '{status: StFull, slot: '0, value: '0};
              state_d = FsmPush;
            end else begin
              cnt_d = cnt_q + IdxW'(1);
            end
          end
          default: begin
            if (hit) begin
              res_d = '{status: StDone, slot: to_slot(cmp_idx_q), value: ram_rdata.value};
              if (cmd_q == CmdDelete) begin
                occ_d[cmp_idx_q] = 1'b0;
              end
              cmp_vld_d = 1'b0;
              state_d   = FsmPush;
            end else if (cmp_vld_q && (cmp_idx_q == LastIdx)) begin
              res_d     = '{status: StNotFound, slot: '0, value: '0};
              cmp_vld_d = 1'b0;
              state_d   = FsmPush;
            end else begin
              // keep one read in flight ahead of the compare
              cmp_vld_d = !issued_all_q;
              if (!issued_all_q) begin
                ram_re    = 1'b1;
                cmp_idx_d = cnt_q;
                if (cnt_q == LastIdx) begin
                  issued_all_d = 1'b1;
                end else begin
                  cnt_d = cnt_q + IdxW'(1);
                end
              end
            end
          end
        endcase
      end

      FsmPush: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_vld_d = 1'b1;
          out_d     = res_q;
          state_d   = FsmIdle;
        end
      end

      default: begin
        state_d = FsmIdle;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= FsmIdle;
      cnt_q        <= '0;
      issued_all_q <= 1'b0;
      cmp_vld_q    <= 1'b0;
      occ_q        <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      issued_all_q <= issued_all_d;
      cmp_vld_q    <= cmp_vld_d;
      occ_q        <= occ_d;
      out_vld_q    <= out_vld_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_e'(req_i.command);
      key_q <= req_i.record_key;
      val_q <= req_i.record_value;
    end
    cmp_idx_q <= cmp_idx_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.status      = out_q.status;
  assign rsp_o.slot_index  = out_q.slot;
  assign rsp_o.found_value = out_q.value;

  // one command at a time: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !req_i.ready)
    else $error("command accepted while another is in work");

  // an insert only ever writes a free slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !occ_q[cnt_q])
    else $error("insert overwrites an occupied slot");

  // a pending compare exists only during a scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> (state_q == FsmScan))
    else $error("compare pending outside a scan");

  // a new result enters the output register only from the push state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> ($past(state_q) == FsmPush))
    else $error("result produced outside the push state");

  // failed commands report zero slot and value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_q.status != StDone)) |-> ((out_q.slot == '0) && (out_q.value == '0)))
    else $error("nonzero slot or value on a failed command");

endmodule
